// ===== design/m24dbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m24dbc_pkg: shared types, constants and the digit divider
// Holds the fixed field widths of the recoder and the radix-256 divide-by-3
// step that the iterative datapath applies to one byte per cycle.
// ----------------------------------------------------------------------------
package m24dbc_pkg;

  localparam int WORD_W = 64;
  localparam int COEF_W = 5;
  localparam int EXP2_W = 9;
  localparam int EXP3_W = 8;

  // Width of one digit handled by the divider per cycle.
  localparam int DIGIT_BITS = 8;

  // A term digit is taken modulo 24 = 2^3 * 3.
  localparam int LOW_BITS = 3;
  localparam logic [1:0] DIVISOR = 2'd3;
  localparam logic [COEF_W-1:0] HALF_MODULUS = 5'd12;
  localparam logic [COEF_W-1:0] MODULUS = 5'd24;

  // Exponent increments applied after each term.
  localparam logic [EXP2_W-1:0] EXP2_STEP = 9'd3;
  localparam logic [EXP3_W-1:0] EXP3_STEP = 8'd1;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] quot;
    logic [1:0]            rem;
  } div3_digit_t;

  // Divides {rem_in, digit} by three with eight restoring steps on a
  // three-bit partial remainder.
  function automatic div3_digit_t div3_digit(input logic [1:0] rem_in,
                                             input logic [DIGIT_BITS-1:0] digit);
    div3_digit_t res;
    logic [1:0] r;
    logic [2:0] t;
    r = rem_in;
    res.quot = '0;
    for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= {1'b0, DIVISOR}) begin
        res.quot[i] = 1'b1;
        t = t - {1'b0, DIVISOR};
      end else begin
        res.quot[i] = 1'b0;
      end
      r = t[1:0];
    end
    res.rem = r;
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/mod24_double_base_chain_recoder.sv =====
// Operation: a word that is not last is stored while the recoder stays idle and busy
// stays low. A last word starts a recoding in which each term of the store is found by
// stripping factors two, byte-serial divide-by-3 passes that strip factors three
// until one fails, a shift by three and a byte-serial divide by 3 for the divide by 24
// and, on a round-up, a byte-serial increment. Terms come one per strobe and cannot be
// stalled; rst (synchronous) clears store and sequencer.
`default_nettype none
// ----------------------------------------------------------------------------
// mod24_double_base_chain_recoder: double-base (2,3) chain recoder
// Loads an unsigned scalar word by word and recodes it into terms
// coefficient * 2^exp_two * 3^exp_three with digits taken modulo 24.
// ----------------------------------------------------------------------------
module mod24_double_base_chain_recoder #(
  parameter int SCALAR_BITS = 256,
  parameter int MAX_TERMS   = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [m24dbc_pkg::WORD_W-1:0]        scalar_word,
  input  wire logic                                 last_word,
  output logic                                      strobe,
  output logic signed [m24dbc_pkg::COEF_W-1:0]      coefficient,
  output logic [m24dbc_pkg::EXP2_W-1:0]             exp_two,
  output logic [m24dbc_pkg::EXP3_W-1:0]             exp_three,
  output logic                                      final_term
);

  import m24dbc_pkg::*;

  // The store is kept as one flat vector so that the datapath can shift and
  // rotate it as a whole. STORE_WORDS words of 64 bits each.
  localparam int STORE_WORDS = (SCALAR_BITS + WORD_W - 1) / WORD_W;
  localparam int VALUE_W     = STORE_WORDS * WORD_W;
  localparam int NUM_DIGITS  = VALUE_W / DIGIT_BITS;
  localparam int PASS_W      = $clog2(NUM_DIGITS);
  localparam int CNT_W       = $clog2(STORE_WORDS + 1);
  localparam int IDX_W       = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int TERM_W      = $clog2(MAX_TERMS);

  // Sequencer states.
  //   S_IDLE   : waiting for words.
  //   S_STRIP2 : shifts out one factor two per cycle while the value is even.
  //   S_TEST3  : one byte-serial divide-by-3 pass; the quotient is kept only
  //              when the remainder is zero, and then the pass repeats.
  //   S_STEP   : decides whether the chain ends and emits the pending term.
  //   S_SHIFT3 : takes off the low three bits (the factor eight of 24).
  //   S_DIV24  : byte-serial divide-by-3 pass that always keeps the quotient.
  //   S_INC    : byte-serial increment, least significant byte first.
  typedef enum logic [2:0] {
    S_IDLE,
    S_STRIP2,
    S_TEST3,
    S_STEP,
    S_SHIFT3,
    S_DIV24,
    S_INC
  } state_t;

  state_t                 state;
  logic [VALUE_W-1:0]     value;       // the scalar store, rotated during passes
  logic [VALUE_W-1:0]     quot;        // quotient collected during a pass
  logic [CNT_W-1:0]       word_count;
  logic [EXP2_W-1:0]      two_exponent;
  logic [EXP3_W-1:0]      three_exponent;
  logic [PASS_W-1:0]      pass_cnt;
  logic [1:0]             pass_rem;
  logic                   inc_carry;
  logic [LOW_BITS-1:0]    low_bits;
  logic                   have_term;
  logic [TERM_W-1:0]      term_count;
  logic [COEF_W-1:0]      pend_coef;
  logic [EXP2_W-1:0]      pend_exp2;
  logic [EXP3_W-1:0]      pend_exp3;

  logic                   accept;
  logic [VALUE_W-1:0]     value_loaded;
  logic [IDX_W-1:0]       word_idx;
  logic [DIGIT_BITS-1:0]  top_digit;
  div3_digit_t            dd;
  logic [VALUE_W-1:0]     quot_next;
  logic [VALUE_W-1:0]     value_rotl;
  logic [DIGIT_BITS:0]    inc_sum;
  logic                   value_zero;
  logic                   pass_last;
  logic [COEF_W-1:0]      digit_r;
  logic                   round_up;
  logic                   chain_end;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Word loading: the next free word slot takes the incoming word. Words past
  // the capacity of the store are dropped.
  assign word_idx = word_count[IDX_W-1:0];

  always_comb begin
    value_loaded = value;
    if (word_count < CNT_W'(STORE_WORDS)) begin
      for (int i = 0; i < STORE_WORDS; i++) begin
        if (word_idx == IDX_W'(i)) begin
          value_loaded[i*WORD_W +: WORD_W] = scalar_word;
        end
      end
    end
  end

  // The shared divide unit works on the most significant byte; the store
  // rotates left by one byte per cycle so that after a full pass it is back in
  // place, while the quotient bytes shift into a separate register.
  assign top_digit  = value[VALUE_W-1 -: DIGIT_BITS];
  assign dd         = div3_digit(pass_rem, top_digit);
  assign quot_next  = {quot[VALUE_W-DIGIT_BITS-1:0], dd.quot};
  assign value_rotl = {value[VALUE_W-DIGIT_BITS-1:0], top_digit};
  assign inc_sum    = {1'b0, value[DIGIT_BITS-1:0]} + {{DIGIT_BITS{1'b0}}, inc_carry};
  assign value_zero = ~|value;
  assign pass_last  = (pass_cnt == PASS_W'(NUM_DIGITS - 1));

  // The residue modulo 24 is the residue of the divide-by-3 pass placed above
  // the three bits taken off before it. Residues of twelve and more round up.
  assign digit_r    = {dd.rem, low_bits};
  assign round_up   = (digit_r >= HALF_MODULUS);

  // The chain ends when nothing is left or the term budget is used up.
  assign chain_end  = value_zero || (term_count == TERM_W'(MAX_TERMS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      value          <= '0;
      word_count     <= '0;
      two_exponent   <= '0;
      three_exponent <= '0;
      pass_cnt       <= '0;
      pass_rem       <= '0;
      inc_carry      <= 1'b0;
      have_term      <= 1'b0;
      term_count     <= '0;
      strobe         <= 1'b0;
      final_term     <= 1'b0;
    end else begin
      // A term leaves from the step state, either the pending one or the
      // single empty term of a zero scalar.
      strobe <= (state == S_STEP) && (have_term || value_zero);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value <= value_loaded;
            if (word_count < CNT_W'(STORE_WORDS)) begin
              word_count <= word_count + CNT_W'(1);
            end
            if (last_word) begin
              two_exponent   <= '0;
              three_exponent <= '0;
              have_term      <= 1'b0;
              term_count     <= '0;
              state          <= S_STRIP2;
            end
          end
        end

        S_STRIP2: begin
          if (!value_zero && !value[0]) begin
            value        <= value >> 1;
            two_exponent <= two_exponent + EXP2_W'(1);
          end else if (value_zero) begin
            state <= S_STEP;
          end else begin
            pass_cnt <= '0;
            pass_rem <= '0;
            state    <= S_TEST3;
          end
        end

        S_TEST3: begin
          quot <= quot_next;
          if (pass_last) begin
            pass_cnt <= '0;
            pass_rem <= '0;
            if (dd.rem == 2'd0) begin
              // Divisible: keep the quotient and try three again.
              value          <= quot_next;
              three_exponent <= three_exponent + EXP3_W'(1);
            end else begin
              value <= value_rotl;
              state <= S_STEP;
            end
          end else begin
            pass_cnt <= pass_cnt + PASS_W'(1);
            pass_rem <= dd.rem;
            value    <= value_rotl;
          end
        end

        S_STEP: begin
          if (!have_term) begin
            if (value_zero) begin
              // A zero scalar gives a single empty term.
              coefficient <= '0;
              exp_two     <= '0;
              exp_three   <= '0;
              final_term  <= 1'b1;
              state       <= S_IDLE;
              word_count  <= '0;
            end else begin
              state <= S_SHIFT3;
            end
          end else begin
            coefficient <= $signed(pend_coef);
            exp_two     <= pend_exp2;
            exp_three   <= pend_exp3;
            final_term  <= chain_end;
            term_count  <= term_count + TERM_W'(1);
            if (chain_end) begin
              // Return to the reset state, ready for the next scalar.
              value          <= '0;
              word_count     <= '0;
              two_exponent   <= '0;
              three_exponent <= '0;
              have_term      <= 1'b0;
              state          <= S_IDLE;
            end else begin
              state <= S_SHIFT3;
            end
          end
        end

        S_SHIFT3: begin
          low_bits <= value[LOW_BITS-1:0];
          value    <= value >> LOW_BITS;
          pass_cnt <= '0;
          pass_rem <= '0;
          state    <= S_DIV24;
        end

        S_DIV24: begin
          quot <= quot_next;
          if (pass_last) begin
            value          <= quot_next;
            pend_coef      <= round_up ? (digit_r - MODULUS) : digit_r;
            pend_exp2      <= two_exponent;
            pend_exp3      <= three_exponent;
            two_exponent   <= two_exponent + EXP2_STEP;
            three_exponent <= three_exponent + EXP3_STEP;
            have_term      <= 1'b1;
            pass_cnt       <= '0;
            pass_rem       <= '0;
            if (round_up) begin
              inc_carry <= 1'b1;
              state     <= S_INC;
            end else begin
              state <= S_STRIP2;
            end
          end else begin
            pass_cnt <= pass_cnt + PASS_W'(1);
            pass_rem <= dd.rem;
            value    <= value_rotl;
          end
        end

        S_INC: begin
          // Rotate right by one byte, adding the carry into the byte that
          // leaves the bottom.
          value     <= {inc_sum[DIGIT_BITS-1:0], value[VALUE_W-1:DIGIT_BITS]};
          inc_carry <= inc_sum[DIGIT_BITS];
          if (pass_last) begin
            pass_cnt <= '0;
            state    <= S_STRIP2;
          end else begin
            pass_cnt <= pass_cnt + PASS_W'(1);
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
